@@ rtl/h2r_pkg.sv @@
// Shared types, constants and a helper function for the HSL to RGB converter.
package h2r_pkg;

   // Hue positions in units of 1/12288 of a turn (one third = 4096)
   localparam int unsigned TURN_UNITS       = 12288;
   localparam int unsigned THIRD_UNITS      = 4096;
   localparam int unsigned SIXTH_UNITS      = 2048;
   localparam int unsigned HALF_UNITS       = 6144;
   localparam int unsigned TWO_THIRDS_UNITS = 8192;

   // Field widths
   localparam int unsigned HUE_W  = 12;
   localparam int unsigned CHAN_W = 8;
   localparam int unsigned POS_W  = 14;  // hue position, 0..12288
   localparam int unsigned LVL_W  = 16;  // q and p over 255*255, 0..65025
   localparam int unsigned RAMP_W = 12;  // ramp offset, 0..2048

   // Segment of the hue ramp that a channel falls in
   typedef enum logic [1:0] {
      SEG_UP   = 2'd0,
      SEG_FLAT = 2'd1,
      SEG_DOWN = 2'd2,
      SEG_LOW  = 2'd3
   } h2r_seg_type;

   // Stage load enables and the stage 3 valid flag shared with the channel datapath
   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
      logic val3;
   } h2r_ctl_type;

   // Exact floor(x / 255) for x up to 65279
   function automatic logic [CHAN_W-1:0] div255(input logic [LVL_W-1:0] x);
      logic [LVL_W:0] sum;
      sum = {1'b0, x} + {9'd0, x[LVL_W-1:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

@@ rtl/hsl_to_rgb_converter_top.sv @@
// Top level of the HSL to RGB pixel converter: stream ports and pipeline control.
//
// Usage:
//   Pixels enter on the req_ stream (tvalid/tready/tdata) and leave as 8-bit
//   RGB on the rsp_ stream. Each transaction carries one pixel; every input
//   transaction gives exactly one output transaction, in order.
//   The datapath is a four-stage pipeline: q/p levels and hue positions,
//   ramp segment selection, ramp multiply, and the scale to 8 bits. A pixel
//   passes through the stages in that order, and while the output is not
//   stalled, one pixel can be accepted every clock cycle.
//   Each stage has its own valid bit and loads when it is empty or when the
//   stage after it moves on, so bubbles collapse. When the receiver holds
//   rsp_tready low the output register keeps its transaction, the stages
//   behind it fill up, and req_tready drops only once all four are full.
//   Synchronous reset clears all valid bits; the payload registers are not
//   reset and no output transaction is shown until new pixels arrive.
//   Zero saturation gives gray at the lightness value on all channels.
module hsl_to_rgb_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [11:0] hue, [19:12] saturation, [27:20] lightness, zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);
   import h2r_pkg::*;

   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] sat, lig;

   // Valid bits and stage load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic a1, a2, a3, a4;
   h2r_ctl_type ctl;

   // Stage 1 payload
   logic [LVL_W-1:0] q1_ff, q1_in, p1_ff, p1_in;
   logic [POS_W-1:0] tr_ff, tr_in, tg_ff, tg_in, tb_ff, tb_in;

   logic [LVL_W-1:0] ls, l255, s255;
   logic [LVL_W:0]   q_sum, l510, p_sum;
   logic [POS_W-1:0] h3;
   logic [POS_W:0]   tr_sum, tb_sum;

   logic [CHAN_W-1:0] red, green, blue;

   assign hue = req_tdata[11:0];
   assign sat = req_tdata[19:12];
   assign lig = req_tdata[27:20];

   // Pipeline flow: a stage loads when empty or when its successor moves
   assign a4 = !v4_ff || rsp_tready;
   assign a3 = !v3_ff || a4;
   assign a2 = !v2_ff || a3;
   assign a1 = !v1_ff || a2;
   assign req_tready = a1;

   assign ctl.load2 = a2 && v1_ff;
   assign ctl.load3 = a3 && v2_ff;
   assign ctl.load4 = a4 && v3_ff;
   assign ctl.val3  = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (a1) v1_ff <= req_tvalid;
         if (a2) v2_ff <= v1_ff;
         if (a3) v3_ff <= v2_ff;
         if (a4) v4_ff <= v3_ff;
      end
   end

   // Form q and p over 255*255 from lightness and saturation
   assign ls   = LVL_W'(lig) * LVL_W'(sat);
   assign l255 = {lig, 8'h00} - {8'h00, lig};
   assign s255 = {sat, 8'h00} - {8'h00, sat};

   always_comb begin
      if (!lig[7]) begin
         q_sum = {1'b0, l255} + {1'b0, ls};
      end else begin
         q_sum = {1'b0, l255} + {1'b0, s255} - {1'b0, ls};
      end
   end

   assign q1_in = q_sum[LVL_W-1:0];
   assign l510  = {lig, 9'd0} - {8'd0, lig, 1'b0};
   assign p_sum = l510 - {1'b0, q1_in};
   assign p1_in = p_sum[LVL_W-1:0];

   // Place each channel on the hue ramp, wrapping past a full turn
   assign h3     = POS_W'({hue, 1'b0}) + POS_W'(hue);
   assign tr_sum = (POS_W+1)'(h3) + (POS_W+1)'(THIRD_UNITS);
   assign tb_sum = (POS_W+1)'(h3) + (POS_W+1)'(TWO_THIRDS_UNITS);

   always_comb begin
      tg_in = h3;
      if (tr_sum > (POS_W+1)'(TURN_UNITS)) begin
         tr_in = POS_W'(tr_sum - (POS_W+1)'(TURN_UNITS));
      end else begin
         tr_in = POS_W'(tr_sum);
      end
      if (tb_sum > (POS_W+1)'(TURN_UNITS)) begin
         tb_in = POS_W'(tb_sum - (POS_W+1)'(TURN_UNITS));
      end else begin
         tb_in = POS_W'(tb_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (a1 && req_tvalid) begin
         q1_ff <= q1_in;
         p1_ff <= p1_in;
         tr_ff <= tr_in;
         tg_ff <= tg_in;
         tb_ff <= tb_in;
      end
   end

   // Channel datapaths, stages 2 through 4
   h2r_channel u_red (
      .clock (clock), .reset (reset), .ctl (ctl),
      .pos (tr_ff), .q_lvl (q1_ff), .p_lvl (p1_ff), .chan (red)
   );

   h2r_channel u_green (
      .clock (clock), .reset (reset), .ctl (ctl),
      .pos (tg_ff), .q_lvl (q1_ff), .p_lvl (p1_ff), .chan (green)
   );

   h2r_channel u_blue (
      .clock (clock), .reset (reset), .ctl (ctl),
      .pos (tb_ff), .q_lvl (q1_ff), .p_lvl (p1_ff), .chan (blue)
   );

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {blue, green, red};

   // Lower level never exceeds the upper level
   a_p_below_q: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (p1_ff <= q1_ff))
      else $error("p level above q level");

   // Input backpressure only when every stage holds a transaction
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled with an empty stage");

   // A stalled first stage keeps its levels
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !a2) |=> ($stable(q1_ff) && $stable(p1_ff) && $stable(tg_ff)))
      else $error("stalled stage 1 changed");

endmodule

@@ rtl/h2r_channel.sv @@
// One color channel: hue ramp segment, ramp interpolation and scale to 8 bits.
module h2r_channel (
   input  logic                      clock,
   input  logic                      reset,
   input  h2r_pkg::h2r_ctl_type      ctl,
   input  logic [h2r_pkg::POS_W-1:0] pos,
   input  logic [h2r_pkg::LVL_W-1:0] q_lvl,
   input  logic [h2r_pkg::LVL_W-1:0] p_lvl,
   output logic [h2r_pkg::CHAN_W-1:0] chan
);
   import h2r_pkg::*;

   // Stage 2 registers
   h2r_seg_type        seg_ff, seg_in;
   logic [RAMP_W-1:0]  ramp_ff, ramp_in;
   logic [LVL_W-1:0]   d_ff, d_in;
   logic [LVL_W-1:0]   q2_ff, p2_ff;
   // Stage 3 and 4 registers
   logic [LVL_W-1:0]   m_ff, m_in;
   logic [CHAN_W-1:0]  chan_ff;

   logic [POS_W-1:0]   down_off;
   logic [27:0]        prod;

   // Classify the hue position and form the ramp offset
   assign down_off = POS_W'(TWO_THIRDS_UNITS) - pos;

   always_comb begin
      d_in    = q_lvl - p_lvl;
      ramp_in = '0;
      if (pos < POS_W'(SIXTH_UNITS)) begin
         seg_in  = SEG_UP;
         ramp_in = RAMP_W'(pos);
      end else if (pos < POS_W'(HALF_UNITS)) begin
         seg_in  = SEG_FLAT;
      end else if (pos < POS_W'(TWO_THIRDS_UNITS)) begin
         seg_in  = SEG_DOWN;
         ramp_in = RAMP_W'(down_off);
      end else begin
         seg_in  = SEG_LOW;
      end
   end

   // Interpolate: p + (q - p) * offset / 2048, else plateau or floor level
   assign prod = 28'(d_ff) * 28'(ramp_ff);

   always_comb begin
      case (seg_ff)
         SEG_UP, SEG_DOWN: m_in = p2_ff + prod[26:11];
         SEG_FLAT:         m_in = q2_ff;
         SEG_LOW:          m_in = p2_ff;
         default:          m_in = p2_ff;
      endcase
   end

   // Advance the payload registers when each stage loads
   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         seg_ff  <= seg_in;
         ramp_ff <= ramp_in;
         d_ff    <= d_in;
         q2_ff   <= q_lvl;
         p2_ff   <= p_lvl;
      end
      if (ctl.load3) begin
         m_ff <= m_in;
      end
      if (ctl.load4) begin
         chan_ff <= div255(m_ff);
      end
   end

   assign chan = chan_ff;

   // Interpolated level stays within the range the divide by 255 handles
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      ctl.val3 |-> (m_ff <= 16'd65025))
      else $error("channel level out of range");

   // A valid stage 3 that does not load keeps its level
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.val3 && !ctl.load3) |=> $stable(m_ff))
      else $error("stalled channel level changed");

endmodule

@@ sim/hsl_to_rgb_converter_top_tb.sv @@
// Self-checking testbench for the HSL to RGB pixel converter stream pipeline.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_top_tb;

   // Hue positions in units of 1/12288 of a turn
   localparam int unsigned HUE_TURN   = 12288;
   localparam int unsigned HUE_THIRD  = 4096;
   localparam int unsigned HUE_SIXTH  = 2048;
   localparam int unsigned HUE_HALF   = 6144;
   localparam int unsigned HUE_TWO_3  = 8192;
   localparam int unsigned RAMP_DEN   = 522240;

   localparam int RANDOM_PIXELS = 1500;
   localparam int MAX_GAP       = 13;
   localparam int TAIL_CYCLES   = 20;
   localparam int CYCLE_LIMIT   = 400000;

   // Field order matches rsp_tdata: red in the lowest byte
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   typedef struct {
      logic [11:0] hue;
      logic [7:0]  sat;
      logic [7:0]  lig;
      int          gap;
      bit          drain;
   } hsl_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [11:0] hue, [19:12] saturation, [27:20] lightness, zeros
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] red_out, [15:8] green_out, [23:16] blue_out

   hsl_pixel_type pixel_queue[$];
   rgb_pixel_type rgb_expect[$];
   hsl_pixel_type pixel_on_bus;
   int       pixels_total = 0;
   int       sent_count = 0;
   int       rgb_count = 0;
   int       fail_count = 0;
   int       send_hold = 0;
   int       recv_stall = 0;
   int       cycle_count = 0;
   bit       send_burst = 1'b0;
   bit       recv_burst = 1'b0;

   hsl_to_rgb_converter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock and reset
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Channel level on the hue ramp; lo and hi are over 255*255
   function automatic logic [7:0] ramp_level(int unsigned lo, int unsigned hi,
                                             int unsigned pos);
      int unsigned span;
      int unsigned level;
      span = hi - lo;
      if (pos < HUE_SIXTH)
         level = (lo * HUE_SIXTH + span * pos) / RAMP_DEN;
      else if (pos < HUE_HALF)
         level = hi / 255;
      else if (pos < HUE_TWO_3)
         level = (lo * HUE_SIXTH + span * (HUE_TWO_3 - pos)) / RAMP_DEN;
      else
         level = lo / 255;
      return level[7:0];
   endfunction

   // Exact HSL to RGB conversion with truncation to 8 bits
   function automatic rgb_pixel_type hsl_to_rgb(logic [11:0] hue, logic [7:0] sat,
                                                logic [7:0] lig);
      int unsigned   h;
      int unsigned   s;
      int unsigned   l;
      int unsigned   hi;
      int unsigned   lo;
      int unsigned   pos_r;
      int unsigned   pos_b;
      rgb_pixel_type px;
      h = hue;
      s = sat;
      l = lig;
      if (l <= 127)
         hi = l * (255 + s);
      else
         hi = 255 * l + 255 * s - l * s;
      lo = 510 * l - hi;
      // shift by a third of a turn each way, wrapping into one turn
      pos_r = 3 * h + HUE_THIRD;
      if (pos_r > HUE_TURN)
         pos_r -= HUE_TURN;
      pos_b = 3 * h + HUE_TURN - HUE_THIRD;
      if (pos_b > HUE_TURN)
         pos_b -= HUE_TURN;
      px.red   = ramp_level(lo, hi, pos_r);
      px.green = ramp_level(lo, hi, 3 * h);
      px.blue  = ramp_level(lo, hi, pos_b);
      return px;
   endfunction

   // Queue one pixel with its idle gap
   task automatic add_pixel(logic [11:0] hue, logic [7:0] sat, logic [7:0] lig,
                            bit drain);
      hsl_pixel_type p;
      p.hue   = hue;
      p.sat   = sat;
      p.lig   = lig;
      p.drain = drain;
      p.gap   = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      pixel_queue.push_back(p);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'(127 + $urandom_range(0, 1));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Driver: present queued pixels, honor gaps and drain requests
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rgb_expect.push_back(hsl_to_rgb(pixel_on_bus.hue, pixel_on_bus.sat,
                                            pixel_on_bus.lig));
            sent_count++;
            send_hold = (pixel_queue.size() > 0) ? pixel_queue[0].gap : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_tvalid <= 1'b0;
            end else if (pixel_queue.size() > 0 &&
                         !(pixel_queue[0].drain && rgb_expect.size() > 0)) begin
               pixel_on_bus = pixel_queue.pop_front();
               req_tdata  <= {4'd0, pixel_on_bus.lig, pixel_on_bus.sat, pixel_on_bus.hue};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall the result side at random and check each transaction
   always @(posedge clock) begin
      rgb_pixel_type want;
      rgb_pixel_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            rgb_count++;
            if (rgb_count % 150 == 0)
               recv_burst = $urandom_range(0, 2) == 0;
            if (rgb_expect.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               fail_count++;
            end else begin
               want = rgb_expect.pop_front();
               if (got.red !== want.red) begin
                  $error("red_out: expected %0d, actual %0d", want.red, got.red);
                  fail_count++;
               end
               if (got.green !== want.green) begin
                  $error("green_out: expected %0d, actual %0d", want.green, got.green);
                  fail_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
                  fail_count++;
               end
            end
            recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus and end of test
   initial begin : stimulus
      logic [11:0] hue;
      // extremes, zero saturation, ramp breakpoints and hue wrap
      add_pixel(12'd0,    8'd0,   8'd0,   1'b0);
      add_pixel(12'd4095, 8'd255, 8'd255, 1'b0);
      add_pixel(12'd0,    8'd255, 8'd128, 1'b0);
      add_pixel(12'd4095, 8'd0,   8'd77,  1'b0);
      add_pixel(12'd1000, 8'd0,   8'd255, 1'b0);
      add_pixel(12'd2222, 8'd0,   8'd128, 1'b0);
      add_pixel(12'd341,  8'd255, 8'd128, 1'b0);
      add_pixel(12'd342,  8'd255, 8'd127, 1'b0);
      add_pixel(12'd682,  8'd128, 8'd100, 1'b0);
      add_pixel(12'd683,  8'd128, 8'd100, 1'b0);
      add_pixel(12'd1365, 8'd255, 8'd127, 1'b0);
      add_pixel(12'd1366, 8'd200, 8'd128, 1'b0);
      add_pixel(12'd2047, 8'd255, 8'd128, 1'b0);
      add_pixel(12'd2048, 8'd255, 8'd128, 1'b0);
      add_pixel(12'd2049, 8'd255, 8'd200, 1'b0);
      add_pixel(12'd2730, 8'd255, 8'd64,  1'b0);
      add_pixel(12'd2731, 8'd255, 8'd192, 1'b0);
      add_pixel(12'd3413, 8'd255, 8'd128, 1'b0);
      add_pixel(12'd3414, 8'd90,  8'd200, 1'b0);
      add_pixel(12'd1024, 8'd170, 8'd85,  1'b0);
      add_pixel(12'd3000, 8'd1,   8'd1,   1'b0);
      add_pixel(12'd2000, 8'd254, 8'd254, 1'b1);

      // random pixels, switching between bursts and gapped traffic
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 100 == 0)
            send_burst = $urandom_range(0, 2) == 0;
         if ($urandom_range(0, 3) == 0)
            hue = 12'(($urandom_range(0, 5) * 2048 + $urandom_range(0, 4)) / 3);
         else
            hue = 12'($urandom_range(0, 4095));
         add_pixel(hue, pick_level(), pick_level(), n % 300 == 299);
      end
      pixels_total = pixel_queue.size();

      wait (sent_count == pixels_total);
      wait (rgb_expect.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && rgb_expect.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
